// ===== src/utcc_pkg.sv =====
`default_nettype none
package utcc_pkg;

  // Command codes
  localparam logic CMD_TO_DATE = 1'b0;
  localparam logic CMD_TO_SECS = 1'b1;

  // Pipeline depth, input register to output register
  localparam int STAGES = 9;

  localparam int SEC_PER_DAY   = 86400;
  localparam int SEC_PER_HOUR  = 3600;
  localparam int SEC_PER_MIN   = 60;
  localparam int DAYS_PER_YEAR = 365;
  localparam int DAYS_PER_WEEK = 7;
  localparam int DAYS_PER_QUAD = 1461;

  // Days from 1900-01-01 to 1970-01-01 with 1900 counted as leap, plus the
  // one-based day offset
  localparam int DAYS_BIAS = 25569;

  // Seconds per day is 128 * 675, so divide by 675 after a 7 bit shift
  localparam int DAY_SHIFT = 7;
  localparam int DAY_ODD   = SEC_PER_DAY / (1 << DAY_SHIFT);

  // Reciprocals, floor(2^k / d), each low by less than one unit of the quotient
  localparam int RECIP_DAY_K  = 34;
  localparam int RECIP_DAY    = 25451658;
  localparam int RECIP_QUAD_K = 20;
  localparam int RECIP_QUAD   = 717;
  localparam int RECIP_WEEK_K = 18;
  localparam int RECIP_WEEK   = 37449;
  localparam int RECIP_HOUR_K = 22;
  localparam int RECIP_HOUR   = 1165;
  localparam int RECIP_MIN_K  = 16;
  localparam int RECIP_MIN    = 1092;

  localparam logic [30:0] SECONDS_MAX = 31'h7FFF_FFFF;

  // Cumulative days before each month, row = year mod 4, row 0 is the leap row
  localparam logic [8:0] CUM_DAYS [64] = '{
    9'd0, 9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
    9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366, 9'd0, 9'd0,
    9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd0, 9'd0,
    9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd0, 9'd0,
    9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd0, 9'd0
  };

endpackage
`default_nettype wire

// ===== src/utcc_req_if.sv =====
`default_nettype none
interface utcc_req_if;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic signed [31:0] seconds_in;
  logic        [7:0] year_in;
  logic        [3:0] month_in;
  logic        [4:0] day_in;
  logic        [4:0] hour_in;
  logic        [5:0] minute_in;
  logic        [5:0] second_in;

  modport source (
    output valid, cmd, seconds_in, year_in, month_in, day_in, hour_in, minute_in,
           second_in,
    input  ready
  );
  modport sink (
    input  valid, cmd, seconds_in, year_in, month_in, day_in, hour_in, minute_in,
           second_in,
    output ready
  );
endinterface
`default_nettype wire

// ===== src/utcc_rsp_if.sv =====
`default_nettype none
interface utcc_rsp_if;
  logic        valid;
  logic        ready;
  logic [30:0] seconds_out;
  logic  [7:0] year_out;
  logic  [3:0] month_out;
  logic  [4:0] day_out;
  logic  [2:0] weekday_out;
  logic  [4:0] hour_out;
  logic  [5:0] minute_out;
  logic  [5:0] second_out;

  modport source (
    output valid, seconds_out, year_out, month_out, day_out, weekday_out, hour_out,
           minute_out, second_out,
    input  ready
  );
  modport sink (
    input  valid, seconds_out, year_out, month_out, day_out, weekday_out, hour_out,
           minute_out, second_out,
    output ready
  );
endinterface
`default_nettype wire

// ===== src/unix_time_calendar_convert.sv =====
// An accepted request beat passes through stage registers 1 to 9 to its response beat.
// Throughput: one beat per cycle while rsp.ready holds; the nine stages each hold one
// item and close up bubbles, so a stalled response holds back only full stages.
// Stage depth is set by one constant-reciprocal multiply or one correction each.
// Reset (rst, synchronous) clears all stage valid bits; data registers are not reset.
`default_nettype none
module unix_time_calendar_convert
  import utcc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  utcc_req_if.sink    req,
  utcc_rsp_if.source  rsp
);

  logic [STAGES:1] v;
  logic [STAGES:1] en;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[STAGES] = !v[STAGES] || rsp.ready;
    for (int i = STAGES - 1; i >= 1; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign req.ready = en[1];
  assign rsp.valid = v[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= req.valid;
      for (int i = 2; i <= STAGES; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // ---------------- stage 1: clamp, day quotient estimate, day count ----------
  logic        s1_cmd;
  logic [23:0] s1_x;
  logic [14:0] s1_q;
  logic  [6:0] s1_tlo;
  logic signed [17:0] s1_days;
  logic  [4:0] s1_hour;
  logic  [5:0] s1_min;
  logic  [5:0] s1_sec;

  logic [30:0] t_clamp;
  logic [48:0] day_prod;
  logic  [5:0] cum_idx;
  logic [16:0] days_pos;

  always_comb begin
    t_clamp  = req.seconds_in[31] ? '0 : req.seconds_in[30:0];
    day_prod = 49'(t_clamp[30:DAY_SHIFT]) * 49'(RECIP_DAY);
    cum_idx  = {req.year_in[1:0], req.month_in};
    days_pos = 17'(req.year_in) * 17'(DAYS_PER_YEAR)
             + 17'((9'(req.year_in) + 9'd3) >> 2)
             + 17'(CUM_DAYS[cum_idx])
             + 17'(req.day_in);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_cmd  <= req.cmd;
      s1_x    <= t_clamp[30:DAY_SHIFT];
      s1_q    <= day_prod[48:RECIP_DAY_K];
      s1_tlo  <= t_clamp[DAY_SHIFT-1:0];
      s1_days <= $signed({1'b0, days_pos}) - 18'(DAYS_BIAS);
      s1_hour <= req.hour_in;
      s1_min  <= req.minute_in;
      s1_sec  <= req.second_in;
    end
  end

  // ---------------- stage 2: day remainder, seconds products ------------------
  logic        s2_cmd;
  logic [14:0] s2_q;
  logic [10:0] s2_r;
  logic  [6:0] s2_tlo;
  logic signed [35:0] s2_dsec;
  logic [16:0] s2_hms;

  logic [24:0] day_rem;

  always_comb begin
    day_rem = 25'(s1_x) - 25'(s1_q) * 25'(DAY_ODD);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_cmd  <= s1_cmd;
      s2_q    <= s1_q;
      s2_r    <= day_rem[10:0];
      s2_tlo  <= s1_tlo;
      s2_dsec <= s1_days * 18'sd86400;
      s2_hms  <= 17'(s1_hour) * 17'(SEC_PER_HOUR) + 17'(s1_min) * 17'(SEC_PER_MIN)
               + 17'(s1_sec);
    end
  end

  // ---------------- stage 3: correct day quotient, total and saturate ---------
  logic        s3_cmd;
  logic [14:0] s3_dse;
  logic [16:0] s3_sod;
  logic [30:0] s3_secs;

  logic signed [36:0] total;
  logic [30:0] secs_sat;
  logic [10:0] r_fix;
  logic [14:0] dse_fix;

  always_comb begin
    total = 37'(s2_dsec) + $signed({20'd0, s2_hms});
    if (total < 0) secs_sat = '0;
    else if (total > $signed({6'd0, SECONDS_MAX})) secs_sat = SECONDS_MAX;
    else secs_sat = total[30:0];
    if (s2_r >= 11'(DAY_ODD)) begin
      r_fix   = s2_r - 11'(DAY_ODD);
      dse_fix = s2_q + 15'd1;
    end else begin
      r_fix   = s2_r;
      dse_fix = s2_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_cmd  <= s2_cmd;
      s3_dse  <= dse_fix;
      s3_sod  <= {r_fix[9:0], s2_tlo};
      s3_secs <= (s2_cmd == CMD_TO_SECS) ? secs_sat : '0;
    end
  end

  // ---------------- stage 4: quotient estimates for quad, week, hour ----------
  logic        s4_cmd;
  logic [30:0] s4_secs;
  logic [14:0] s4_dp;
  logic [14:0] s4_wv;
  logic [16:0] s4_sod;
  logic  [4:0] s4_c0;
  logic [12:0] s4_w0;
  logic  [5:0] s4_h0;

  logic [14:0] dp;
  logic [14:0] wv;
  logic [24:0] quad_prod;
  logic [30:0] week_prod;
  logic [27:0] hour_prod;

  always_comb begin
    dp        = s3_dse + 15'(DAYS_PER_YEAR);
    wv        = s3_dse + 15'd4;
    quad_prod = 25'(dp) * 25'(RECIP_QUAD);
    week_prod = 31'(wv) * 31'(RECIP_WEEK);
    hour_prod = 28'(s3_sod) * 28'(RECIP_HOUR);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_cmd  <= s3_cmd;
      s4_secs <= s3_secs;
      s4_dp   <= dp;
      s4_wv   <= wv;
      s4_sod  <= s3_sod;
      s4_c0   <= quad_prod[24:RECIP_QUAD_K];
      s4_w0   <= week_prod[30:RECIP_WEEK_K];
      s4_h0   <= hour_prod[27:RECIP_HOUR_K];
    end
  end

  // ---------------- stage 5: remainders ---------------------------------------
  logic        s5_cmd;
  logic [30:0] s5_secs;
  logic  [4:0] s5_c0;
  logic [11:0] s5_r1;
  logic  [3:0] s5_rw;
  logic  [5:0] s5_h0;
  logic [12:0] s5_rh;

  logic [14:0] quad_rem;
  logic [14:0] week_rem;
  logic [16:0] hour_rem;

  always_comb begin
    quad_rem = s4_dp - 15'(s4_c0) * 15'(DAYS_PER_QUAD);
    week_rem = s4_wv - 15'(s4_w0) * 15'(DAYS_PER_WEEK);
    hour_rem = s4_sod - 17'(s4_h0) * 17'(SEC_PER_HOUR);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_cmd  <= s4_cmd;
      s5_secs <= s4_secs;
      s5_c0   <= s4_c0;
      s5_r1   <= quad_rem[11:0];
      s5_rw   <= week_rem[3:0];
      s5_h0   <= s4_h0;
      s5_rh   <= hour_rem[12:0];
    end
  end

  // ---------------- stage 6: correct quad, weekday, hour ----------------------
  logic        s6_cmd;
  logic [30:0] s6_secs;
  logic  [4:0] s6_c;
  logic [10:0] s6_r;
  logic  [2:0] s6_wday;
  logic  [4:0] s6_hour;
  logic [11:0] s6_rem;

  logic  [4:0] c_fix;
  logic [11:0] r1_fix;
  logic  [3:0] rw_fix;
  logic  [5:0] h_fix;
  logic [12:0] rh_fix;

  always_comb begin
    if (s5_r1 >= 12'(DAYS_PER_QUAD)) begin
      c_fix  = s5_c0 + 5'd1;
      r1_fix = s5_r1 - 12'(DAYS_PER_QUAD);
    end else begin
      c_fix  = s5_c0;
      r1_fix = s5_r1;
    end
    rw_fix = (s5_rw >= 4'(DAYS_PER_WEEK)) ? s5_rw - 4'(DAYS_PER_WEEK) : s5_rw;
    if (s5_rh >= 13'(SEC_PER_HOUR)) begin
      h_fix  = s5_h0 + 6'd1;
      rh_fix = s5_rh - 13'(SEC_PER_HOUR);
    end else begin
      h_fix  = s5_h0;
      rh_fix = s5_rh;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_cmd  <= s5_cmd;
      s6_secs <= s5_secs;
      s6_c    <= c_fix;
      s6_r    <= r1_fix[10:0];
      s6_wday <= rw_fix[2:0] + 3'd1;
      s6_hour <= h_fix[4:0];
      s6_rem  <= rh_fix[11:0];
    end
  end

  // ---------------- stage 7: year within quad, minute estimate ----------------
  logic        s7_cmd;
  logic [30:0] s7_secs;
  logic  [7:0] s7_year;
  logic  [8:0] s7_dyr;
  logic  [2:0] s7_wday;
  logic  [4:0] s7_hour;
  logic [11:0] s7_rem;
  logic  [5:0] s7_m0;

  logic  [1:0] yic;
  logic [10:0] dyr_w;
  logic [21:0] min_prod;

  always_comb begin
    if (s6_r >= 11'(3 * DAYS_PER_YEAR)) yic = 2'd3;
    else if (s6_r >= 11'(2 * DAYS_PER_YEAR)) yic = 2'd2;
    else if (s6_r >= 11'(DAYS_PER_YEAR)) yic = 2'd1;
    else yic = 2'd0;
    dyr_w    = s6_r - 11'(yic) * 11'(DAYS_PER_YEAR);
    min_prod = 22'(s6_rem) * 22'(RECIP_MIN);
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_cmd  <= s6_cmd;
      s7_secs <= s6_secs;
      s7_year <= 8'd69 + {1'b0, s6_c, 2'b00} + 8'(yic);
      s7_dyr  <= dyr_w[8:0];
      s7_wday <= s6_wday;
      s7_hour <= s6_hour;
      s7_rem  <= s6_rem;
      s7_m0   <= min_prod[21:RECIP_MIN_K];
    end
  end

  // ---------------- stage 8: month search, second remainder -------------------
  logic        s8_cmd;
  logic [30:0] s8_secs;
  logic  [7:0] s8_year;
  logic  [3:0] s8_month;
  logic  [8:0] s8_dyr;
  logic  [2:0] s8_wday;
  logic  [4:0] s8_hour;
  logic  [5:0] s8_m0;
  logic  [6:0] s8_rs;

  logic  [3:0] mon;
  logic [11:0] sec_rem;

  // Count month starts already passed; the table row rises monotonically
  always_comb begin
    mon = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (s7_dyr >= CUM_DAYS[{s7_year[1:0], 4'(k)}]) mon = mon + 4'd1;
    end
    sec_rem = s7_rem - 12'(s7_m0) * 12'(SEC_PER_MIN);
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_cmd   <= s7_cmd;
      s8_secs  <= s7_secs;
      s8_year  <= s7_year;
      s8_month <= mon;
      s8_dyr   <= s7_dyr;
      s8_wday  <= s7_wday;
      s8_hour  <= s7_hour;
      s8_m0    <= s7_m0;
      s8_rs    <= sec_rem[6:0];
    end
  end

  // ---------------- stage 9: day of month, minute fix, output register -------
  logic [30:0] s9_secs;
  logic  [7:0] s9_year;
  logic  [3:0] s9_month;
  logic  [4:0] s9_day;
  logic  [2:0] s9_wday;
  logic  [4:0] s9_hour;
  logic  [5:0] s9_min;
  logic  [5:0] s9_sec;

  logic [8:0] dom;
  logic [5:0] min_fix;
  logic [6:0] sec_fix;
  logic       is_date;

  always_comb begin
    dom     = s8_dyr - CUM_DAYS[{s8_year[1:0], s8_month}] + 9'd1;
    min_fix = (s8_rs >= 7'(SEC_PER_MIN)) ? s8_m0 + 6'd1 : s8_m0;
    sec_fix = (s8_rs >= 7'(SEC_PER_MIN)) ? s8_rs - 7'(SEC_PER_MIN) : s8_rs;
    is_date = (s8_cmd == CMD_TO_DATE);
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_secs  <= s8_secs;
      s9_year  <= is_date ? s8_year : '0;
      s9_month <= is_date ? s8_month : '0;
      s9_day   <= is_date ? dom[4:0] : '0;
      s9_wday  <= is_date ? s8_wday : '0;
      s9_hour  <= is_date ? s8_hour : '0;
      s9_min   <= is_date ? min_fix : '0;
      s9_sec   <= is_date ? sec_fix[5:0] : '0;
    end
  end

  assign rsp.seconds_out = s9_secs;
  assign rsp.year_out    = s9_year;
  assign rsp.month_out   = s9_month;
  assign rsp.day_out     = s9_day;
  assign rsp.weekday_out = s9_wday;
  assign rsp.hour_out    = s9_hour;
  assign rsp.minute_out  = s9_min;
  assign rsp.second_out  = s9_sec;

  // ---------------- assertions -------------------------------------------------
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> v[1])
    else $error("accepted beat did not enter stage 1");

  a_ready_only_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (&v) && !rsp.ready)
    else $error("request stalled while the pipeline has room");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    v[6] && s6_cmd == CMD_TO_DATE |-> s6_hour <= 5'd23 && s6_rem < 12'(SEC_PER_HOUR)
      && s6_wday >= 3'd1)
    else $error("hour split out of range");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    v[8] && s8_cmd == CMD_TO_DATE |-> s8_month >= 4'd1 && s8_month <= 4'd12
      && s8_dyr <= 9'(DAYS_PER_YEAR))
    else $error("month search out of range");

endmodule
`default_nettype wire

// ===== test/unix_time_calendar_convert_checker.sv =====
`timescale 1ns / 1ps
module unix_time_calendar_convert_checker
  import utcc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  utcc_req_if       req,
  utcc_rsp_if       rsp,
  output int        mismatches,
  output int        outstanding
);

  typedef struct packed {
    logic [30:0] seconds;
    logic  [7:0] year;
    logic  [3:0] month;
    logic  [4:0] day;
    logic  [2:0] weekday;
    logic  [4:0] hour;
    logic  [5:0] minute;
    logic  [5:0] second;
  } conversion_t;

  conversion_t conversions_due[$];

  // Days from 1970-01-01 to Jan 1 of the given year, negative before 1970
  function automatic longint days_before_year(longint year);
    longint span;
    span = year - 69;
    return 365 * (year - 70) + (span >>> 2);
  endfunction

  // Days before the month within the year; months outside 1..13 add nothing
  function automatic longint days_before_month(logic [7:0] year, logic [3:0] month);
    longint d;
    case (month)
      4'd2:    d = 31;
      4'd3:    d = 59;
      4'd4:    d = 90;
      4'd5:    d = 120;
      4'd6:    d = 151;
      4'd7:    d = 181;
      4'd8:    d = 212;
      4'd9:    d = 243;
      4'd10:   d = 273;
      4'd11:   d = 304;
      4'd12:   d = 334;
      4'd13:   d = 365;
      default: d = 0;
    endcase
    // every fourth year carries Feb 29
    if (year[1:0] == 2'b00 && month >= 4'd3 && month <= 4'd13) d = d + 1;
    return d;
  endfunction

  function automatic conversion_t convert(logic cmd, logic signed [31:0] secs,
                                          logic [7:0] yr, logic [3:0] mon,
                                          logic [4:0] dom, logic [4:0] hr,
                                          logic [5:0] mn, logic [5:0] sc);
    conversion_t r;
    longint t, dse, day, year, total;
    logic [3:0] m;
    r = '0;
    if (cmd == CMD_TO_DATE) begin
      // clamp negative time to the epoch
      t = (secs < 0) ? 64'sd0 : longint'(secs);
      dse = t / SEC_PER_DAY;
      year = dse / DAYS_PER_YEAR + 72;
      // walk the year guess down until the day lands inside it
      do begin
        year = year - 1;
        day = dse - days_before_year(year);
      end while (day < 0);
      m = 4'd1;
      while (m < 4'd12 && day >= days_before_month(year[7:0], m + 4'd1)) m = m + 4'd1;
      r.year    = year[7:0];
      r.month   = m;
      r.day     = 5'(day - days_before_month(year[7:0], m) + 1);
      r.weekday = 3'((dse + 4) % DAYS_PER_WEEK + 1);
      r.hour    = 5'((t % SEC_PER_DAY) / SEC_PER_HOUR);
      r.minute  = 6'((t % SEC_PER_HOUR) / SEC_PER_MIN);
      r.second  = 6'(t % SEC_PER_MIN);
    end else begin
      total = (days_before_year(longint'(yr)) + days_before_month(yr, mon)
               + longint'(dom) - 1) * SEC_PER_DAY
            + longint'(hr) * SEC_PER_HOUR + longint'(mn) * SEC_PER_MIN + longint'(sc);
      // saturate at zero and at the top of the signed 32-bit range
      if (total < 0) total = 0;
      if (total > 64'sd2147483647) total = 64'sd2147483647;
      r.seconds = total[30:0];
    end
    return r;
  endfunction

  task automatic flag_result(string what, conversion_t want, conversion_t got);
    if (mismatches < 10)
      $display("%0t %s: exp secs=%0d %0d-%0d-%0d wd=%0d %0d:%0d:%0d / got secs=%0d %0d-%0d-%0d wd=%0d %0d:%0d:%0d",
               $time, what, want.seconds, want.year, want.month, want.day, want.weekday,
               want.hour, want.minute, want.second, got.seconds, got.year, got.month,
               got.day, got.weekday, got.hour, got.minute, got.second);
    mismatches = mismatches + 1;
  endtask

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  // Match response beats against the oldest prediction, then log new requests
  always @(posedge clk) begin : watch
    conversion_t got, want;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.seconds_out, rsp.year_out, rsp.month_out, rsp.day_out,
                rsp.weekday_out, rsp.hour_out, rsp.minute_out, rsp.second_out};
        if (conversions_due.size() == 0) begin
          flag_result("unexpected beat", '0, got);
        end else begin
          want = conversions_due.pop_front();
          if (got.seconds !== want.seconds || got.year !== want.year ||
              got.month !== want.month || got.day !== want.day ||
              got.weekday !== want.weekday || got.hour !== want.hour ||
              got.minute !== want.minute || got.second !== want.second)
            flag_result("mismatch", want, got);
        end
      end
      if (req.valid && req.ready)
        conversions_due.push_back(convert(req.cmd, req.seconds_in, req.year_in,
                                          req.month_in, req.day_in, req.hour_in,
                                          req.minute_in, req.second_in));
    end
    outstanding = conversions_due.size();
  end

endmodule

// ===== test/unix_time_calendar_convert_tb.sv =====
`timescale 1ns / 1ps
module unix_time_calendar_convert_tb;
  import utcc_pkg::*;

  localparam int IDLE_LIMIT   = 5000;
  localparam int RANDOM_ITEMS = 1200;

  logic clk;
  logic rst;
  logic steady;
  int   mismatches;
  int   outstanding;
  int   quiet_cycles;

  utcc_req_if req_ch();
  utcc_rsp_if rsp_ch();

  unix_time_calendar_convert dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  unix_time_calendar_convert_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stall the response side about a third of the time, never while steady
  always @(posedge clk) begin
    rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 33);
  end

  // Abort when no beat moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("** unix_time_calendar_convert: FAILED **");
        $finish;
      end
    end
  end

  // Offer one request beat, with a random gap ahead of it, and hold until taken
  task automatic send(input logic cmd, input logic [31:0] secs, input logic [7:0] yr,
                      input logic [3:0] mon, input logic [4:0] dom, input logic [4:0] hr,
                      input logic [5:0] mn, input logic [5:0] sc);
    while (!steady && $urandom_range(0, 99) < 33) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= cmd;
    req_ch.seconds_in <= secs;
    req_ch.year_in    <= yr;
    req_ch.month_in   <= mon;
    req_ch.day_in     <= dom;
    req_ch.hour_in    <= hr;
    req_ch.minute_in  <= mn;
    req_ch.second_in  <= sc;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  initial begin
    logic [31:0] secs;
    int sel;
    int pick;
    rst = 1'b1;
    steady = 1'b0;
    quiet_cycles = 0;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_TO_DATE;
    req_ch.seconds_in = '0;
    req_ch.year_in = '0;
    req_ch.month_in = '0;
    req_ch.day_in = '0;
    req_ch.hour_in = '0;
    req_ch.minute_in = '0;
    req_ch.second_in = '0;
    rsp_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Seconds to date: epoch, negative clamp, top of range, day and leap edges
    send(CMD_TO_DATE, 32'd0, 8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send(CMD_TO_DATE, 32'hFFFF_FFFF, 8'hFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F);
    send(CMD_TO_DATE, 32'h8000_0000, 8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send(CMD_TO_DATE, 32'h7FFF_FFFF, 8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send(CMD_TO_DATE, 32'd86399, 8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send(CMD_TO_DATE, 32'd86400, 8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send(CMD_TO_DATE, 32'd68169600, 8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send(CMD_TO_DATE, 32'd946684799, 8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send(CMD_TO_DATE, 32'd951782400, 8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send(CMD_TO_DATE, 32'd951868799, 8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);

    // Date to seconds: epoch, exact limit, saturation, pre-1970 clamp, odd fields
    send(CMD_TO_SECS, 32'd0, 8'd70, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    send(CMD_TO_SECS, 32'd0, 8'd138, 4'd1, 5'd19, 5'd3, 6'd14, 6'd7);
    send(CMD_TO_SECS, 32'd0, 8'd138, 4'd1, 5'd19, 5'd3, 6'd14, 6'd8);
    send(CMD_TO_SECS, 32'hFFFF_FFFF, 8'd255, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
    send(CMD_TO_SECS, 32'd0, 8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send(CMD_TO_SECS, 32'd0, 8'd69, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    send(CMD_TO_SECS, 32'd0, 8'd100, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0);
    send(CMD_TO_SECS, 32'd0, 8'd100, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0);
    send(CMD_TO_SECS, 32'd0, 8'd101, 4'd14, 5'd5, 5'd0, 6'd0, 6'd0);
    send(CMD_TO_SECS, 32'd0, 8'd72, 4'd3, 5'd0, 5'd0, 6'd0, 6'd0);
    send(CMD_TO_SECS, 32'd0, 8'd80, 4'd6, 5'd15, 5'd31, 6'd63, 6'd63);

    // Random mix; a middle stretch runs with neither side idling
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady <= (n >= 500 && n < 700);
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        pick = $urandom_range(0, 3);
        case (pick)
          0:       secs = $urandom;
          1:       secs = $urandom_range(0, 24855) * 86400 + $urandom_range(0, 2);
          default: secs = $urandom_range(0, 32'h7FFF_FFFF);
        endcase
        send(CMD_TO_DATE, secs, 8'($urandom), 4'($urandom), 5'($urandom),
             5'($urandom), 6'($urandom), 6'($urandom));
      end else if (sel < 85) begin
        send(CMD_TO_SECS, $urandom, 8'($urandom_range(70, 138)),
             4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)),
             5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
             6'($urandom_range(0, 59)));
      end else begin
        send(CMD_TO_SECS, $urandom, 8'($urandom), 4'($urandom), 5'($urandom),
             5'($urandom), 6'($urandom), 6'($urandom));
      end
    end
    req_ch.valid <= 1'b0;
    steady <= 1'b0;

    // Drain, then let the pipeline settle
    while (outstanding != 0) @(posedge clk);
    repeat (STAGES + 8) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("** unix_time_calendar_convert: PASSED **");
    end else begin
      $display("** unix_time_calendar_convert: FAILED **");
    end
    $finish;
  end

endmodule
